### hdl/dlb_pkg.sv
package dlb_pkg;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Fixed field widths of the stream payloads
    localparam int DEGREE_IN_W    = 32;
    localparam int ENTRY_IDX_W    = 6;
    localparam int BUCKET_START_W = 32;
    localparam int IN_USE_W       = 6;
    localparam int OUT_TDATA_W    = 48;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MSB    = 7'b0000010,
        ST_CNT_RD = 7'b0000100,
        ST_CNT_WR = 7'b0001000,
        ST_EM_RD  = 7'b0010000,
        ST_EM_ADD = 7'b0100000,
        ST_EM_OUT = 7'b1000000
    } state_t;

    // Control strobes to the count store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } ram_ctrl_t;

endpackage

### hdl/degree_log2_bucket_offsets_core.sv
// Log2 degree histogram with bucket start offsets.
// Input stream: tuser selects the request (0 adds one node degree carried in
// tdata[31:0], 1 finishes the run). Only the low DEGREE_BITS of the degree count.
// Output stream: on finish, DEGREE_BITS+2 transactions, one per offset entry,
// carrying entry index, saturated prefix sum and buckets in use; tlast marks
// the final entry. A degree request produces no output.
// cfg_we/cfg_wdata write sorted_mode; it is sampled when a finish is accepted.
// A degree request passes through the iterative msb search and then the
// read-modify-write of the count store. A finish walks the entries: per entry
// one store read, one pass through the shared saturating adder and one output
// transaction.
// s_axis_tready is high only while the sequencer is idle.
// When the receiver stalls, the current entry is held in the output register
// and the walk pauses. After the last entry all counts, the node total and the
// occupancy clear, and the block is ready again.
// Reset: async active low; counts, node total, mode and all handshakes clear.
module degree_log2_bucket_offsets_core
    import dlb_pkg::*;
#(
    parameter int DEGREE_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DEGREE_IN_W-1:0] s_axis_tdata,   // node_degree
    input  logic                   s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // entry_index, bucket_start, buckets_in_use
    output logic                   m_axis_tlast    // last_entry
);

    localparam int NUM_ENTRIES = DEGREE_BITS + 2;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    state_t                     state_reg, state_next;
    logic                       mode_reg, mode_next;
    logic                       sorted_reg, sorted_next;
    logic [COUNT_BITS-1:0]      node_total_reg, node_total_next;
    logic [IDX_W-1:0]           max_reg, max_next;
    logic [IDX_W-1:0]           entry_reg, entry_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [COUNT_BITS-1:0]      run_reg, run_next;
    logic                       ovalid_reg, ovalid_next;
    logic [ENTRY_IDX_W-1:0]     oidx_reg, oidx_next;
    logic [BUCKET_START_W-1:0]  ostart_reg, ostart_next;
    logic [IN_USE_W-1:0]        ouse_reg, ouse_next;
    logic                       olast_reg, olast_next;

    logic                       in_fire;
    logic                       out_fire;
    logic [63:0]                deg_wide;
    logic [DEGREE_BITS-1:0]     degree;
    logic                       msb_start;
    logic                       msb_done;
    logic [IDX_W-1:0]           msb_entry;
    ram_ctrl_t                  ram_ctrl;
    logic [IDX_W-1:0]           ram_raddr;
    logic [COUNT_BITS-1:0]      ram_rdata;
    logic [COUNT_BITS-1:0]      add_a, add_b, add_sum;
    logic [COUNT_BITS-1:0]      em_val;
    logic                       is_last;
    logic [63:0]                sum_wide;

    // Input accepted only while idle
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign deg_wide = {32'b0, s_axis_tdata};
    assign degree   = deg_wide[DEGREE_BITS-1:0];
    assign msb_start = in_fire && (s_axis_tuser == REQ_ADD);
    assign is_last  = (idx_reg == IDX_W'(NUM_ENTRIES - 1));

    // Top set bit search
    dlb_msb_unit #(
        .DEGREE_BITS (DEGREE_BITS),
        .IDX_W       (IDX_W)
    ) u_msb (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (msb_start),
        .degree (degree),
        .done   (msb_done),
        .entry  (msb_entry)
    );

    // Per-entry counters
    dlb_count_ram #(
        .DEPTH      (NUM_ENTRIES),
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ram_ctrl),
        .raddr (ram_raddr),
        .waddr (entry_reg),
        .wdata (add_sum),
        .rdata (ram_rdata)
    );

    // Shared saturating adder
    dlb_sat_add #(
        .COUNT_BITS (COUNT_BITS)
    ) u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    // Value of the entry being emitted in the current mode
    assign em_val = sorted_reg ? ram_rdata :
                    ((idx_reg == IDX_W'(1)) ? node_total_reg : '0);

    // Adder operand selection by phase
    always_comb
    begin
        unique case (state_reg)
            ST_EM_ADD:
            begin
                add_a = run_reg;
                add_b = em_val;
            end
            ST_CNT_WR:
            begin
                add_a = ram_rdata;
                add_b = COUNT_BITS'(1);
            end
            default:
            begin
                add_a = node_total_reg;
                add_b = COUNT_BITS'(1);
            end
        endcase
    end

    assign sum_wide = 64'(add_sum);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        sorted_next     = sorted_reg;
        node_total_next = node_total_reg;
        max_next        = max_reg;
        entry_next      = entry_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        ovalid_next     = ovalid_reg;
        oidx_next       = oidx_reg;
        ostart_next     = ostart_reg;
        ouse_next       = ouse_reg;
        olast_next      = olast_reg;
        ram_ctrl        = '0;
        ram_raddr       = entry_reg;

        if (cfg_we)
            mode_next = cfg_wdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == REQ_ADD)
                    begin
                        node_total_next = add_sum;
                        state_next      = ST_MSB;
                    end
                    else
                    begin
                        sorted_next = mode_reg;
                        idx_next    = '0;
                        run_next    = '0;
                        state_next  = ST_EM_RD;
                    end
                end
            end
            ST_MSB:
            begin
                if (msb_done)
                begin
                    entry_next = msb_entry;
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD:
            begin
                ram_ctrl.rd_en = 1'b1;
                state_next     = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                ram_ctrl.wr_en = 1'b1;
                if (entry_reg > max_reg)
                    max_next = entry_reg;
                state_next = ST_IDLE;
            end
            ST_EM_RD:
            begin
                ram_ctrl.rd_en = 1'b1;
                ram_raddr      = idx_reg;
                state_next     = ST_EM_ADD;
            end
            ST_EM_ADD:
            begin
                run_next    = add_sum;
                ovalid_next = 1'b1;
                oidx_next   = ENTRY_IDX_W'(idx_reg);
                ostart_next = sum_wide[BUCKET_START_W-1:0];
                ouse_next   = sorted_reg ? IN_USE_W'(max_reg) : IN_USE_W'(1);
                olast_next  = is_last;
                state_next  = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (out_fire)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        ram_ctrl.clear  = 1'b1;
                        node_total_next = '0;
                        max_next        = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            node_total_reg <= '0;
            max_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            node_total_reg <= node_total_next;
            max_reg        <= max_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        sorted_reg <= sorted_next;
        entry_reg  <= entry_next;
        idx_reg    <= idx_next;
        run_reg    <= run_next;
        oidx_reg   <= oidx_next;
        ostart_reg <= ostart_next;
        ouse_reg   <= ouse_next;
        olast_reg  <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - ENTRY_IDX_W - BUCKET_START_W - IN_USE_W){1'b0}},
                            ouse_reg, ostart_reg, oidx_reg};
    assign m_axis_tlast  = olast_reg;

    // Output only presented in the output phase
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_EM_OUT))
        else $error("output valid outside output phase");

    // No input accepted while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while output pending");

    // Last entry ends the walk and returns to idle with cleared totals
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> (state_reg == ST_IDLE) && (node_total_reg == '0) && (max_reg == '0))
        else $error("finish did not clear state");

    // Emitted entry index stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (idx_reg <= IDX_W'(NUM_ENTRIES - 1)))
        else $error("entry index out of range");

    // Occupancy never exceeds the highest entry
    assert property (@(posedge clk) disable iff (!rst_n)
        max_reg <= IDX_W'(NUM_ENTRIES - 1))
        else $error("occupancy out of range");

endmodule

### hdl/dlb_sat_add.sv
module dlb_sat_add #(
    parameter int COUNT_BITS = 32
) (
    input  logic [COUNT_BITS-1:0] a,
    input  logic [COUNT_BITS-1:0] b,
    output logic [COUNT_BITS-1:0] sum
);

    logic [COUNT_BITS:0] full_sum;

    // Add with carry out; clamp to all ones on overflow
    assign full_sum = {1'b0, a} + {1'b0, b};
    assign sum      = full_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : full_sum[COUNT_BITS-1:0];

endmodule

### hdl/dlb_msb_unit.sv
module dlb_msb_unit #(
    parameter int DEGREE_BITS = 32,
    parameter int IDX_W       = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEGREE_BITS-1:0] degree,
    output logic                   done,
    output logic [IDX_W-1:0]       entry
);

    localparam int STEPS = $clog2(DEGREE_BITS);
    localparam int PAD_W = 1 << STEPS;

    logic [PAD_W-1:0] val_reg, val_next;
    logic [STEPS-1:0] sh_reg, sh_next;
    logic [STEPS-1:0] pos_reg, pos_next;
    logic             nz_reg, nz_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PAD_W-1:0] hi_part;
    logic             take;

    // Binary search for the top set bit: one halving step per cycle
    assign hi_part = val_reg >> sh_reg;
    assign take    = |hi_part;

    always_comb
    begin
        val_next  = val_reg;
        sh_next   = sh_reg;
        pos_next  = pos_reg;
        nz_next   = nz_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = PAD_W'(degree);
            sh_next   = STEPS'(PAD_W / 2);
            pos_next  = '0;
            nz_next   = |degree;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                val_next = hi_part;
                pos_next = pos_reg | sh_reg;
            end
            if (sh_reg == STEPS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                sh_next = sh_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sh_reg  <= sh_next;
        pos_reg <= pos_next;
        nz_reg  <= nz_next;
    end

    // Degree zero lands in entry 1, otherwise entry = msb position + 2
    assign done  = done_reg;
    assign entry = nz_reg ? (IDX_W'(pos_reg) + IDX_W'(2)) : IDX_W'(1);

endmodule

### hdl/dlb_count_ram.sv
module dlb_count_ram
    import dlb_pkg::*;
#(
    parameter int DEPTH      = 34,
    parameter int IDX_W      = 6,
    parameter int COUNT_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ram_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]      raddr,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [COUNT_BITS-1:0] wdata,
    output logic [COUNT_BITS-1:0] rdata
);

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  rvalid_reg;

    // Per-entry valid bits; an entry not yet written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
                valid_reg <= '0;
            else if (ctrl.wr_en)
                valid_reg[waddr] <= 1'b1;
            if (ctrl.rd_en)
                rvalid_reg <= valid_reg[raddr];
        end
    end

    // Storage array, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[waddr] <= wdata;
        if (ctrl.rd_en)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### verif/degree_log2_bucket_offsets_core_tb.sv
`timescale 1ns / 1ps

module degree_log2_bucket_offsets_core_tb
    import dlb_pkg::*;
();

    localparam int DEGREE_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int NUM_ENTRIES = DEGREE_BITS + 2;
    localparam int SETTLE_CYCLES = 24;      // wait for a pending degree request to finish
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 250;

    // Output tdata layout, low bit up
    localparam int IDX_LSB    = 0;
    localparam int START_LSB  = IDX_LSB + ENTRY_IDX_W;
    localparam int IN_USE_LSB = START_LSB + BUCKET_START_W;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0]    entry_index;
        logic [BUCKET_START_W-1:0] bucket_start;
        logic [IN_USE_W-1:0]       buckets_in_use;
        logic                      last_entry;
    } offset_entry_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic                   cfg_wdata     = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DEGREE_IN_W-1:0] s_axis_tdata  = '0;
    logic                   s_axis_tuser  = REQ_ADD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // Predictor state: histogram, node total and mode
    count_t        hist_count [NUM_ENTRIES];
    count_t        nodes_counted;
    logic          sorted_mode_q;
    offset_entry_t offsets_due [$];

    int  failures     = 0;
    int  items_sent   = 0;
    int  burst_left   = 0;
    bit  sender_gaps  = 1'b1;
    int  cycle_count  = 0;

    degree_log2_bucket_offsets_core #(
        .DEGREE_BITS (DEGREE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stalls: a 16-bit ready pattern stepped through bit by bit, reshuffled every so often
    logic [15:0] ready_pattern = '1;
    int          ready_phase   = 0;
    int          ready_window  = 0;

    always @(posedge clk)
    begin
        if (ready_window == 0)
        begin
            ready_window  = $urandom_range(16, 200);
            ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
            ready_pattern[0] = 1'b1;
        end
        ready_window--;
        m_axis_tready <= ready_pattern[ready_phase];
        ready_phase = (ready_phase + 1) % 16;
    end

    // Bucket entry hit by one degree: 1 for degree zero, else msb position + 2
    function automatic int degree_entry(input logic [DEGREE_IN_W-1:0] degree);
        logic [DEGREE_BITS-1:0] d;
        int e;
        d = degree[DEGREE_BITS-1:0];
        e = 1;
        for (int b = 0; b < DEGREE_BITS; b++)
            if (d[b])
                e = b + 2;
        return e;
    endfunction

    function automatic count_t count_inc(input count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void count_degree(input logic [DEGREE_IN_W-1:0] degree);
        int e;
        e = degree_entry(degree);
        if (e < NUM_ENTRIES)
            hist_count[e] = count_inc(hist_count[e]);
        nodes_counted = count_inc(nodes_counted);
    endfunction

    // Finish: queue the saturating prefix sums, then clear the histogram
    function automatic void emit_offsets();
        count_t              vals [NUM_ENTRIES];
        logic [COUNT_BITS:0] sum;
        count_t              run;
        int                  in_use;
        offset_entry_t       ent;
        in_use = 0;
        run    = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (sorted_mode_q)
                vals[i] = hist_count[i];
            else
                vals[i] = (i == 1) ? nodes_counted : '0;
            if (sorted_mode_q && vals[i] != '0)
                in_use = i;
        end
        if (!sorted_mode_q)
            in_use = 1;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            sum = {1'b0, run} + {1'b0, vals[i]};
            run = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
            ent.entry_index    = ENTRY_IDX_W'(i);
            ent.bucket_start   = BUCKET_START_W'(run);
            ent.buckets_in_use = IN_USE_W'(in_use);
            ent.last_entry     = (i == NUM_ENTRIES - 1);
            offsets_due.push_back(ent);
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
            hist_count[i] = '0;
        nodes_counted = '0;
    endfunction

    // Output check against the oldest queued offset entry
    always @(posedge clk)
    begin
        offset_entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (offsets_due.size() == 0)
            begin
                $error("offset entry with none pending: tdata %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = offsets_due.pop_front();
                if (m_axis_tdata[IDX_LSB +: ENTRY_IDX_W] !== want.entry_index)
                begin
                    $error("entry_index expected %0d got %0d", want.entry_index,
                           m_axis_tdata[IDX_LSB +: ENTRY_IDX_W]);
                    failures++;
                end
                if (m_axis_tdata[START_LSB +: BUCKET_START_W] !== want.bucket_start)
                begin
                    $error("bucket_start expected %0d got %0d", want.bucket_start,
                           m_axis_tdata[START_LSB +: BUCKET_START_W]);
                    failures++;
                end
                if (m_axis_tdata[IN_USE_LSB +: IN_USE_W] !== want.buckets_in_use)
                begin
                    $error("buckets_in_use expected %0d got %0d", want.buckets_in_use,
                           m_axis_tdata[IN_USE_LSB +: IN_USE_W]);
                    failures++;
                end
                if (m_axis_tlast !== want.last_entry)
                begin
                    $error("last_entry expected %0b got %0b", want.last_entry, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    // One input transaction; a burst gap may be inserted before it
    task automatic send_item(input logic kind, input logic [DEGREE_IN_W-1:0] degree);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= degree;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (kind == REQ_FINISH)
            emit_offsets();
        else
            count_degree(degree);
    endtask

    task automatic send_degree(input logic [DEGREE_IN_W-1:0] degree);
        send_item(REQ_ADD, degree);
    endtask

    task automatic send_finish();
        send_item(REQ_FINISH, DEGREE_IN_W'($urandom));
    endtask

    // Drop valid, wait for all offsets, then let a pending degree settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (offsets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sorted_mode_q = mode;
        @(posedge clk);
    endtask

    // Degree with a random msb position and random bits below it
    function automatic logic [DEGREE_IN_W-1:0] shaped_degree();
        int                   msb;
        logic [DEGREE_IN_W:0] mask;
        logic [DEGREE_IN_W-1:0] d;
        msb = $urandom_range(0, DEGREE_BITS);
        if (msb == 0)
            return '0;
        mask = ((DEGREE_IN_W+1)'(1) << (msb - 1)) - 1'b1;
        d = DEGREE_IN_W'($urandom) & mask[DEGREE_IN_W-1:0];
        d[msb-1] = 1'b1;
        return d;
    endfunction

    // Empty runs in both modes
    task automatic test_empty_finish();
        send_finish();
        wait_idle();
        write_mode(1'b1);
        send_finish();
        wait_idle();
    endtask

    // Degree extremes in sorted mode
    task automatic test_degree_extremes();
        send_degree(32'h0000_0000);
        send_degree(32'h0000_0001);
        send_degree(32'h0000_0002);
        send_degree(32'h0000_0003);
        send_degree(32'h5555_5555);
        send_degree(32'hAAAA_AAAA);
        send_degree(32'h7FFF_FFFF);
        send_degree(32'h8000_0000);
        send_degree(32'hFFFF_FFFF);
        send_degree(32'h0000_0000);
        send_finish();
        wait_idle();
    endtask

    // Single bucket holds the node total
    task automatic test_unsorted_total();
        write_mode(1'b0);
        send_degree(32'hFFFF_FFFF);
        send_degree(32'h0000_0007);
        send_degree(32'h0000_0000);
        send_finish();
        wait_idle();
    endtask

    // Mode is taken at finish, not while counting
    task automatic test_mode_switch();
        write_mode(1'b1);
        send_degree(32'd1);
        send_degree(32'd100);
        wait_idle();
        write_mode(1'b0);
        send_finish();
        wait_idle();
        send_degree(32'd5);
        send_degree(32'd6);
        wait_idle();
        write_mode(1'b1);
        send_finish();
        wait_idle();
    endtask

    // Random runs of degrees closed by a finish, mode changed between runs
    task automatic test_random_runs();
        int start_count;
        int run_len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_mode(1'($urandom_range(0, 1)));
            end
            run_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
            for (int n = 0; n < run_len; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_degree(DEGREE_IN_W'($urandom));
                else
                    send_degree(shaped_degree());
                // occasional mode change in the middle of a run
                if ($urandom_range(0, 19) == 0)
                begin
                    wait_idle();
                    write_mode(1'($urandom_range(0, 1)));
                end
            end
            send_finish();
        end
        sender_gaps = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
            hist_count[i] = '0;
        nodes_counted = '0;
        sorted_mode_q = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_finish();
        test_degree_extremes();
        test_unsorted_total();
        test_mode_switch();
        test_random_runs();

        if (failures == 0 && offsets_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/dlb_pkg.sv
hdl/dlb_sat_add.sv
hdl/dlb_msb_unit.sv
hdl/dlb_count_ram.sv
hdl/degree_log2_bucket_offsets_core.sv
verif/degree_log2_bucket_offsets_core_tb.sv
